@@ src/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the periodic task scheduler
// Command codes, slot modes, slot, command and result records, and the slot tick function.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int PRIORITY_LEVELS = 4;
    localparam int QUEUE_DEPTH     = 8;

    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_CREATE  = 3'd1;
    localparam logic [2:0] FUNC_SUSPEND = 3'd2;
    localparam logic [2:0] FUNC_RESUME  = 3'd3;
    localparam logic [2:0] FUNC_KILL    = 3'd4;

    localparam logic [1:0] MODE_DORMANT   = 2'd0;
    localparam logic [1:0] MODE_WAITING   = 2'd1;
    localparam logic [1:0] MODE_READY     = 2'd2;
    localparam logic [1:0] MODE_SUSPENDED = 2'd3;

    typedef struct packed {
        logic [15:0] ident;
        logic [31:0] reload;
        logic [31:0] countdown;
        logic [31:0] delay;
        logic [1:0]  mode;
    } slot_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  priority_req;
        logic [15:0] task_id;
        logic [31:0] period;
        logic [31:0] initial_delay;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] task_out;
        logic [1:0]  prio_out;
        logic [2:0]  position;
        logic        status;
        logic        last;
    } result_t;

    // Advance one slot by one tick: delay, then period countdown.
    function automatic slot_t tick_slot(slot_t s);
        slot_t   r;
        logic [31:0] c;
        r = s;
        c = s.countdown;
        if (r.mode == MODE_DORMANT) begin
            if (r.delay == 32'd0)
                r.mode = MODE_WAITING;
            else
                r.delay = r.delay - 32'd1;
        end
        if (r.mode == MODE_WAITING) begin
            if (c == 32'd0 || c >= r.reload) begin
                r.mode = MODE_READY;
                c = r.reload;
            end
            r.countdown = c - 32'd1;
        end
        return r;
    endfunction

endpackage

@@ src/pts_if.sv @@
// ----------------------------------------------------------------------------
// pts_cmd_if / pts_res_if: valid-ready channels of the scheduler
// Command channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface pts_cmd_if;
    logic         valid;
    logic         ready;
    logic [2:0]   func;
    logic [2:0]   priority_req;
    logic [15:0]  task_id;
    logic [31:0]  period;
    logic [31:0]  initial_delay;
    modport source (output valid, func, priority_req, task_id, period, initial_delay,
                    input ready);
    modport sink (input valid, func, priority_req, task_id, period, initial_delay,
                  output ready);
endinterface

interface pts_res_if;
    logic         valid;
    logic         ready;
    logic         kind;
    logic [15:0]  task_out;
    logic [1:0]   prio_out;
    logic [2:0]   position;
    logic         status;
    logic         last;
    modport source (output valid, kind, task_out, prio_out, position, status, last,
                    input ready);
    modport sink (input valid, kind, task_out, prio_out, position, status, last,
                  output ready);
endinterface

@@ src/pts_cell.sv @@
// ----------------------------------------------------------------------------
// pts_cell: one slot of the rotating slot ring
// Holds one slot record. On each step it takes the slot held by its
// upstream neighbor; the tail cell takes the slot from the head stage.
// ----------------------------------------------------------------------------
module pts_cell (
    input  logic                 clk,
    input  logic                 shift,
    input  pts_pkg::slot_t       up_slot,
    output pts_pkg::slot_t       slot
);

    pts_pkg::slot_t slot_reg;
    pts_pkg::slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (shift)
            slot_next = up_slot;
    end

    // slot payload has no reset value; queue counts gate every read
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

@@ src/periodic_priority_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler: priority-queued periodic task dispatcher
// Slots live in a ring of cells that rotates one place per cycle, while a
// command runs, past a single head stage that ticks, matches, creates,
// removes or emits them; the ring waits while a held result has nowhere to
// go. A command's status transaction follows a full pass of the ring; tick
// results trail their slot by one ready slot. A new command is taken only
// once the last one is done. Reset clears the control state and queue
// counts; slot contents are not reset.
// ----------------------------------------------------------------------------
module periodic_priority_task_scheduler #(
    parameter int PRIORITY_LEVELS = pts_pkg::PRIORITY_LEVELS,
    parameter int QUEUE_DEPTH     = pts_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    pts_cmd_if.sink   cmd,
    pts_res_if.source res
);

    localparam int NSLOT = PRIORITY_LEVELS * QUEUE_DEPTH;
    localparam int PW    = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int NXT   = (NSLOT > 1) ? 1 : 0;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Ring: cell 0 is the head; each step cell i takes cell i+1, the last
    // cell takes the processed head. After NSLOT steps order is restored.
    pts_pkg::slot_t ring [NSLOT];
    pts_pkg::slot_t head_new;
    logic           step;

    logic [1:0]     state_reg, state_next;
    pts_pkg::cmd_t  cmd_reg, cmd_next;
    logic [SW-1:0]  pos_reg, pos_next;          // position within queue
    logic [PW-1:0]  pq_reg, pq_next;            // queue of head slot
    logic [CW-1:0]  qcnt_reg [PRIORITY_LEVELS];
    logic [CW-1:0]  qcnt_next [PRIORITY_LEVELS];
    logic           found_reg, found_next;
    logic           removing_reg, removing_next; // kill: shifting later slots
    logic [SW-1:0]  fpos_reg, fpos_next;
    logic [PW-1:0]  fpq_reg, fpq_next;
    pts_pkg::result_t out_reg, out_next;
    logic           outv_reg, outv_next;
    pts_pkg::result_t hold_reg, hold_next;    // last ready result held back
    logic           holdv_reg, holdv_next;

    genvar gi;
    generate
        for (gi = 0; gi < NSLOT; gi++)
        begin : g_cell
            if (gi == NSLOT - 1)
            begin : g_tail
                pts_cell u_cell (
                    .clk     (clk),
                    .shift   (step),
                    .up_slot (head_new),
                    .slot    (ring[gi])
                );
            end
            else
            begin : g_body
                pts_cell u_cell (
                    .clk     (clk),
                    .shift   (step),
                    .up_slot (ring[gi + 1]),
                    .slot    (ring[gi])
                );
            end
        end
    endgenerate

    logic           in_use;
    logic           out_free;
    logic           stall;
    logic           last_pos;
    logic           last_step;
    logic           ok_prio;
    logic           cre_here;
    logic           hit;
    pts_pkg::slot_t hs, nx, ts;
    logic [PW-1:0]  cp;

    assign cp        = cmd_reg.priority_req[PW-1:0];
    assign out_free  = !outv_reg || res.ready;
    // ring waits only while a held result has nowhere to go
    assign stall     = holdv_reg && !out_free;
    assign in_use    = (CW'(pos_reg) < qcnt_reg[pq_reg]);
    assign last_pos  = (pos_reg == SW'(QUEUE_DEPTH - 1));
    assign last_step = last_pos && (pq_reg == PW'(PRIORITY_LEVELS - 1));
    assign ok_prio   = ({1'b0, cmd_reg.priority_req} < 4'(PRIORITY_LEVELS));
    assign cre_here  = ok_prio && (pq_reg == cp) &&
                       (CW'(pos_reg) == qcnt_reg[pq_reg]) && !found_reg;
    assign hs        = ring[0];
    assign nx        = ring[NXT];
    assign hit       = in_use && !found_reg && (hs.ident == cmd_reg.task_id);
    assign ts        = pts_pkg::tick_slot(hs);
    assign cmd.ready = (state_reg == ST_IDLE);
    assign res.valid = outv_reg;
    assign res.kind     = out_reg.kind;
    assign res.task_out = out_reg.task_out;
    assign res.prio_out = out_reg.prio_out;
    assign res.position = out_reg.position;
    assign res.status   = out_reg.status;
    assign res.last     = out_reg.last;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        pq_next       = pq_reg;
        qcnt_next     = qcnt_reg;
        found_next    = found_reg;
        removing_next = removing_reg;
        fpos_next     = fpos_reg;
        fpq_next      = fpq_reg;
        out_next      = out_reg;
        outv_next     = outv_reg && !res.ready;
        hold_next     = hold_reg;
        holdv_next    = holdv_reg;
        head_new      = hs;
        step          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next.func          = cmd.func;
                    cmd_next.priority_req  = cmd.priority_req;
                    cmd_next.task_id       = cmd.task_id;
                    cmd_next.period        = cmd.period;
                    cmd_next.initial_delay = cmd.initial_delay;
                    pos_next      = '0;
                    pq_next       = '0;
                    found_next    = 1'b0;
                    removing_next = 1'b0;
                    holdv_next    = 1'b0;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!stall)
                begin
                    step = 1'b1;
                    case (cmd_reg.func)
                        pts_pkg::FUNC_TICK:
                        begin
                            if (in_use)
                            begin
                                head_new = ts;
                                if (ts.mode == pts_pkg::MODE_READY)
                                begin
                                    head_new.mode = pts_pkg::MODE_WAITING;
                                    if (holdv_reg)
                                    begin
                                        out_next  = hold_reg;
                                        outv_next = 1'b1;
                                    end
                                    hold_next.kind     = 1'b0;
                                    hold_next.task_out = hs.ident;
                                    hold_next.prio_out = 2'(pq_reg);
                                    hold_next.position = 3'(pos_reg);
                                    hold_next.status   = 1'b0;
                                    hold_next.last     = 1'b0;
                                    holdv_next         = 1'b1;
                                end
                            end
                        end
                        pts_pkg::FUNC_CREATE:
                        begin
                            if (cre_here)
                            begin
                                head_new.ident     = cmd_reg.task_id;
                                head_new.reload    = cmd_reg.period;
                                head_new.countdown = cmd_reg.period;
                                head_new.delay     = cmd_reg.initial_delay;
                                head_new.mode      = pts_pkg::MODE_DORMANT;
                                found_next = 1'b1;
                                fpos_next  = pos_reg;
                                fpq_next   = pq_reg;
                                qcnt_next[pq_reg] = qcnt_reg[pq_reg] + CW'(1);
                            end
                        end
                        pts_pkg::FUNC_SUSPEND, pts_pkg::FUNC_RESUME, pts_pkg::FUNC_KILL:
                        begin
                            // after a kill, each later slot of that queue
                            // takes its successor, closing the gap
                            if (removing_reg && (pq_reg == fpq_reg))
                                head_new = nx;
                            if (hit)
                            begin
                                found_next = 1'b1;
                                fpos_next  = pos_reg;
                                fpq_next   = pq_reg;
                                if (cmd_reg.func == pts_pkg::FUNC_SUSPEND)
                                    head_new.mode = pts_pkg::MODE_SUSPENDED;
                                else if (cmd_reg.func == pts_pkg::FUNC_RESUME)
                                    head_new.mode = pts_pkg::MODE_READY;
                                else
                                begin
                                    head_new      = nx;
                                    removing_next = 1'b1;
                                    qcnt_next[pq_reg] = qcnt_reg[pq_reg] - CW'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (last_pos)
                    begin
                        pos_next = '0;
                        pq_next  = pq_reg + PW'(1);
                    end
                    else
                        pos_next = pos_reg + SW'(1);
                    if (last_step)
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (cmd_reg.func == pts_pkg::FUNC_TICK)
                    begin
                        if (holdv_reg)
                        begin
                            out_next      = hold_reg;
                            out_next.last = 1'b1;
                            outv_next     = 1'b1;
                            holdv_next    = 1'b0;
                        end
                    end
                    else
                    begin
                        out_next.kind     = 1'b1;
                        out_next.task_out = cmd_reg.task_id;
                        out_next.last     = 1'b1;
                        if (found_reg)
                        begin
                            out_next.prio_out = 2'(fpq_reg);
                            out_next.position = 3'(fpos_reg);
                            out_next.status   = 1'b0;
                        end
                        else
                        begin
                            out_next.prio_out = '0;
                            out_next.position = '0;
                            out_next.status   = 1'b1;
                        end
                        outv_next = 1'b1;
                    end
                    removing_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            outv_reg     <= 1'b0;
            holdv_reg    <= 1'b0;
            found_reg    <= 1'b0;
            removing_reg <= 1'b0;
            for (int i = 0; i < PRIORITY_LEVELS; i++)
                qcnt_reg[i] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            outv_reg     <= outv_next;
            holdv_reg    <= holdv_next;
            found_reg    <= found_next;
            removing_reg <= removing_next;
            qcnt_reg     <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pos_reg  <= pos_next;
        pq_reg   <= pq_next;
        fpos_reg <= fpos_next;
        fpq_reg  <= fpq_next;
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == ST_RUN))
        else $error("command not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !holdv_reg)
        else $error("held result left at idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (outv_reg && !res.ready) |=> $stable(out_reg))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (outv_reg && !res.ready) |=> outv_reg)
        else $error("result dropped while stalled");

endmodule

@@ tb/periodic_priority_task_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler_tb: self-checking bench for the scheduler
// Drives commands and ticks over the valid-ready command channel, keeps its
// own model of the priority queues and compares every result transaction.
// ----------------------------------------------------------------------------
module periodic_priority_task_scheduler_tb;

    localparam int LEVELS     = pts_pkg::PRIORITY_LEVELS;
    localparam int DEPTH      = pts_pkg::QUEUE_DEPTH;
    localparam int RING_LAT   = LEVELS * DEPTH;
    localparam int CYCLE_CAP  = 600000;
    localparam int N_RANDOM   = 80;
    localparam int HOLD_LEN   = 400;
    localparam logic [2:0] FUNC_UNUSED_LO = pts_pkg::FUNC_KILL + 3'd1;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    logic clk;
    logic rst_n;

    pts_cmd_if cmd ();
    pts_res_if res ();

    periodic_priority_task_scheduler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    // scheduler shadow state
    int          q_len      [LEVELS];
    logic [15:0] s_ident    [LEVELS][DEPTH];
    logic [31:0] s_reload   [LEVELS][DEPTH];
    logic [31:0] s_count    [LEVELS][DEPTH];
    logic [31:0] s_delay    [LEVELS][DEPTH];
    logic [1:0]  s_mode     [LEVELS][DEPTH];

    pts_pkg::result_t pending_results[$];

    int src_idle;
    int snk_idle;
    bit hold_go;
    int n_errors;
    int n_ticks;
    int n_dispatched;
    int n_commands;
    int n_rejects;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // result checker
    initial
    begin
        pts_pkg::result_t got;
        pts_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
            begin
                got = '{res.kind, res.task_out, res.prio_out, res.position,
                        res.status, res.last};
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("Unexpected result transaction %p", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("Mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    function automatic pts_pkg::result_t status_result(logic [15:0] id, int p, int s,
                                                       bit bad);
        pts_pkg::result_t r;
        r.kind     = 1'b1;
        r.task_out = id;
        r.prio_out = bad ? 2'd0 : p[1:0];
        r.position = bad ? 3'd0 : s[2:0];
        r.status   = bad;
        r.last     = 1'b1;
        return r;
    endfunction

    task automatic advance_schedule();
        pts_pkg::result_t r;
        int first;
        first = pending_results.size();
        n_ticks++;
        for (int p = 0; p < LEVELS; p++)
            for (int s = 0; s < q_len[p]; s++)
            begin
                if (s_mode[p][s] == pts_pkg::MODE_DORMANT)
                begin
                    if (s_delay[p][s] == 32'd0)
                        s_mode[p][s] = pts_pkg::MODE_WAITING;
                    else
                        s_delay[p][s]--;
                end
                if (s_mode[p][s] == pts_pkg::MODE_WAITING)
                begin
                    logic [31:0] c;
                    c = s_count[p][s];
                    if (c == 32'd0 || c >= s_reload[p][s])
                    begin
                        s_mode[p][s] = pts_pkg::MODE_READY;
                        c = s_reload[p][s];
                    end
                    s_count[p][s] = c - 32'd1;
                end
            end
        for (int p = 0; p < LEVELS; p++)
            for (int s = 0; s < q_len[p]; s++)
                if (s_mode[p][s] == pts_pkg::MODE_READY)
                begin
                    r = '{1'b0, s_ident[p][s], p[1:0], s[2:0], 1'b0, 1'b0};
                    pending_results.push_back(r);
                    s_mode[p][s] = pts_pkg::MODE_WAITING;
                    n_dispatched++;
                end
        if (pending_results.size() > first)
            pending_results[$].last = 1'b1;
    endtask

    task automatic apply_command(pts_pkg::cmd_t c);
        int fp;
        int fs;
        bit hit;
        n_commands++;
        if (c.func == pts_pkg::FUNC_TICK)
        begin
            n_commands--;
            advance_schedule();
        end
        else if (c.func == pts_pkg::FUNC_CREATE)
        begin
            if (c.priority_req >= LEVELS || q_len[c.priority_req] >= DEPTH)
            begin
                n_rejects++;
                pending_results.push_back(status_result(c.task_id, 0, 0, 1'b1));
            end
            else
            begin
                fp = int'(c.priority_req);
                fs = q_len[fp];
                s_ident[fp][fs]  = c.task_id;
                s_reload[fp][fs] = c.period;
                s_count[fp][fs]  = c.period;
                s_delay[fp][fs]  = c.initial_delay;
                s_mode[fp][fs]   = pts_pkg::MODE_DORMANT;
                q_len[fp]++;
                pending_results.push_back(status_result(c.task_id, fp, fs, 1'b0));
            end
        end
        else if (c.func == pts_pkg::FUNC_SUSPEND || c.func == pts_pkg::FUNC_RESUME ||
                 c.func == pts_pkg::FUNC_KILL)
        begin
            hit = 1'b0;
            fp = 0;
            fs = 0;
            for (int p = 0; p < LEVELS && !hit; p++)
                for (int s = 0; s < q_len[p] && !hit; s++)
                    if (s_ident[p][s] == c.task_id)
                    begin
                        hit = 1'b1;
                        fp = p;
                        fs = s;
                    end
            if (!hit)
            begin
                n_rejects++;
                pending_results.push_back(status_result(c.task_id, 0, 0, 1'b1));
            end
            else
            begin
                if (c.func == pts_pkg::FUNC_SUSPEND)
                    s_mode[fp][fs] = pts_pkg::MODE_SUSPENDED;
                else if (c.func == pts_pkg::FUNC_RESUME)
                    s_mode[fp][fs] = pts_pkg::MODE_READY;
                else
                begin
                    for (int k = fs; k + 1 < q_len[fp]; k++)
                    begin
                        s_ident[fp][k]  = s_ident[fp][k + 1];
                        s_reload[fp][k] = s_reload[fp][k + 1];
                        s_count[fp][k]  = s_count[fp][k + 1];
                        s_delay[fp][k]  = s_delay[fp][k + 1];
                        s_mode[fp][k]   = s_mode[fp][k + 1];
                    end
                    q_len[fp]--;
                end
                pending_results.push_back(status_result(c.task_id, fp, fs, 1'b0));
            end
        end
        else
        begin
            n_rejects++;
            pending_results.push_back(status_result(c.task_id, 0, 0, 1'b1));
        end
    endtask

    // called and returns at a falling edge; valid stays high between
    // back-to-back transactions
    task automatic send_cmd(pts_pkg::cmd_t c);
        while ($urandom_range(99) < src_idle)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid         <= 1'b1;
        cmd.func          <= c.func;
        cmd.priority_req  <= c.priority_req;
        cmd.task_id       <= c.task_id;
        cmd.period        <= c.period;
        cmd.initial_delay <= c.initial_delay;
        do
            @(posedge clk);
        while (!cmd.ready);
        apply_command(c);
        @(negedge clk);
    endtask

    function automatic pts_pkg::cmd_t make_cmd(logic [2:0] f, logic [2:0] p,
                                               logic [15:0] id, logic [31:0] per,
                                               logic [31:0] dly);
        pts_pkg::cmd_t c;
        c.func          = f;
        c.priority_req  = p;
        c.task_id       = id;
        c.period        = per;
        c.initial_delay = dly;
        return c;
    endfunction

    function automatic pts_pkg::cmd_t tick_cmd();
        return make_cmd(pts_pkg::FUNC_TICK, 3'($urandom), 16'($urandom), $urandom,
                        $urandom);
    endfunction

    task automatic drain();
        cmd.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (RING_LAT + 8) @(negedge clk);
    endtask

    task automatic test_directed();
        // full queue at the last level (3), then rejections on overflow and on out-of-range levels
        for (int i = 0; i < DEPTH; i++)
            send_cmd(make_cmd(pts_pkg::FUNC_CREATE, 3'd3, 16'h0100 + i[15:0], i[31:0],
                              32'd0));
        send_cmd(make_cmd(pts_pkg::FUNC_CREATE, 3'd3, 16'hFFFF, 32'd1, 32'd1));
        send_cmd(make_cmd(pts_pkg::FUNC_CREATE, 3'd7, 16'h0000, 32'd1, 32'd0));
        send_cmd(make_cmd(pts_pkg::FUNC_CREATE, 3'd4, 16'h0001, 32'd1, 32'd0));
        // zero period, max period, max delay
        send_cmd(make_cmd(pts_pkg::FUNC_CREATE, 3'd0, 16'hFFFF, 32'd0, 32'd0));
        send_cmd(make_cmd(pts_pkg::FUNC_CREATE, 3'd1, 16'h0000, 32'hFFFF_FFFF, 32'd0));
        send_cmd(make_cmd(pts_pkg::FUNC_CREATE, 3'd2, 16'h5A5A, 32'd2, 32'hFFFF_FFFF));
        send_cmd(tick_cmd());
        send_cmd(tick_cmd());
        send_cmd(make_cmd(pts_pkg::FUNC_SUSPEND, 3'd0, 16'hFFFF, 32'd0, 32'd0));
        send_cmd(make_cmd(pts_pkg::FUNC_RESUME, 3'd0, 16'h5A5A, 32'd0, 32'd0));
        send_cmd(tick_cmd());
        send_cmd(make_cmd(pts_pkg::FUNC_KILL, 3'd0, 16'h0103, 32'd0, 32'd0));
        send_cmd(make_cmd(pts_pkg::FUNC_KILL, 3'd0, 16'hBEEF, 32'd0, 32'd0));
        send_cmd(make_cmd(pts_pkg::FUNC_SUSPEND, 3'd0, 16'hBEEF, 32'd0, 32'd0));
        send_cmd(make_cmd(pts_pkg::FUNC_RESUME, 3'd0, 16'hFFFF, 32'd0, 32'd0));
        for (int f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++)
            send_cmd(make_cmd(f[2:0], 3'd7, 16'hA5A5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_cmd(tick_cmd());
        drain();
    endtask

    function automatic pts_pkg::cmd_t random_cmd();
        pts_pkg::cmd_t c;
        int pick;
        c = make_cmd(pts_pkg::FUNC_TICK, 3'($urandom_range(3)), 16'($urandom_range(15)),
                     32'($urandom_range(4)), 32'($urandom_range(3)));
        pick = $urandom_range(99);
        if (pick < 8)
            // noise: arbitrary fields, any func
            c = make_cmd(3'($urandom), 3'($urandom), 16'($urandom), $urandom, $urandom);
        else if (pick < 40)
            c.func = pts_pkg::FUNC_TICK;
        else if (pick < 65)
        begin
            c.func = pts_pkg::FUNC_CREATE;
            if ($urandom_range(9) == 0)
                c.period = $urandom;
            if ($urandom_range(9) == 0)
                c.priority_req = 3'($urandom_range(7));
        end
        else if (pick < 75)
            c.func = pts_pkg::FUNC_SUSPEND;
        else if (pick < 85)
            c.func = pts_pkg::FUNC_RESUME;
        else
            c.func = pts_pkg::FUNC_KILL;
        return c;
    endfunction

    task automatic test_random(int n, int s_idle, int r_idle);
        src_idle = s_idle;
        snk_idle = r_idle;
        for (int i = 0; i < n; i++)
            send_cmd(random_cmd());
        drain();
    endtask

    task automatic test_backpressure();
        src_idle = 0;
        snk_idle = 0;
        for (int i = 0; i < DEPTH; i++)
            send_cmd(make_cmd(pts_pkg::FUNC_CREATE, 3'd0, 16'h7000 + i[15:0], 32'd0,
                              32'd0));
        hold_go = 1'b1;
        // every slot fires each tick while results are held off
        for (int i = 0; i < 6; i++)
            send_cmd(tick_cmd());
        drain();
    endtask

    initial
    begin
        n_errors     = 0;
        n_ticks      = 0;
        n_dispatched = 0;
        n_commands   = 0;
        n_rejects    = 0;
        src_idle     = 0;
        snk_idle     = 0;
        hold_go      = 1'b0;
        for (int p = 0; p < LEVELS; p++)
            q_len[p] = 0;
        rst_n             = 1'b0;
        cmd.valid         = 1'b0;
        cmd.func          = pts_pkg::FUNC_TICK;
        cmd.priority_req  = '0;
        cmd.task_id       = '0;
        cmd.period        = '0;
        cmd.initial_delay = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(N_RANDOM / 4, 0, 0);
        test_random(N_RANDOM / 4, 46, 0);
        test_random(N_RANDOM / 4, 0, 46);
        test_random(N_RANDOM / 4, 6, 6);
        test_backpressure();

        $display("Covered %0d ticks with %0d dispatches, %0d commands (%0d rejected)",
                 n_ticks, n_dispatched, n_commands, n_rejects);
        $display("Mismatches: %0d", n_errors);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
